// ----- design/kst_pkg.sv -----
package kst_pkg;

  localparam int KeyWidth  = 16;
  localparam int DataWidth = 32;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_FIND   = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic                 vld;
    logic [KeyWidth-1:0]  key;
    logic [DataWidth-1:0] data;
  } entry_t;

endpackage

// ----- design/kst_ram.sv -----
module kst_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  kst_pkg::entry_t wr_entry,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output kst_pkg::entry_t rd_entry
);
  import kst_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // Read sees the old contents when the same entry is written on the same edge.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

// ----- design/keyed_slot_table.sv -----
// Add and find scan the active slots one per cycle; the next item is accepted only after
// the result has been registered and the hold state has passed. Remove reads and clears
// the indexed entry (an index beyond the table skips the read); clear sweeps all SLOTS
// entries. A result still waiting holds the next one back.
// Reset is synchronous; afterwards a clearing pass marks every slot empty while no item
// is accepted (configuration writes are still taken).
module keyed_slot_table #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [15:0] key_id,
  input  logic [31:0] entry_data,
  input  logic [3:0]  slot_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [3:0]  slot_out,
  output logic [31:0] data_out,
  output logic [4:0]  live_count
);
  import kst_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [5:0] {
    S_SWEEP  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_RCHK   = 6'b001000,
    S_FINISH = 6'b010000,
    S_HOLD   = 6'b100000
  } state_t;

  state_t state;

  logic [4:0]           cfg_active;
  logic [CW-1:0]        lim, lim_next;
  logic [1:0]           mode_r;
  logic [KeyWidth-1:0]  key_r;
  logic [DataWidth-1:0] data_r;
  logic [IW-1:0]        ridx;
  logic                 init;
  logic [IW-1:0]        sw;
  logic [CW-1:0]        iss;
  logic [IW-1:0]        chk;
  logic                 pend;
  logic                 found_free;
  logic [IW-1:0]        free_idx;
  logic                 hit;
  logic [IW-1:0]        hit_idx;
  logic [DataWidth-1:0] hit_data;
  logic [CW-1:0]        count;
  logic [2:0]           st_r;
  logic [IW-1:0]        slot_r;
  logic [DataWidth-1:0] dout_r;

  logic        accept;
  logic        idx_in_range;
  logic [31:0] idx_wide;

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        wr_entry, rd_entry;

  assign in_ready     = (state == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign idx_wide     = 32'(slot_index);
  assign idx_in_range = (idx_wide < SLOTS);

  always_comb begin
    if (cfg_active == 5'd0) begin
      lim_next = CW'(1);
    end else if (32'(cfg_active) > SLOTS) begin
      lim_next = CW'(SLOTS);
    end else begin
      lim_next = CW'(cfg_active);
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = iss[IW-1:0];
    if (accept && mode == MODE_REMOVE && idx_in_range) begin
      rd_en   = 1'b1;
      rd_addr = idx_wide[IW-1:0];
    end else if (state == S_SCAN && iss < lim) begin
      rd_en = 1'b1;
    end
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = sw;
    wr_entry = '{vld: 1'b1, key: key_r, data: data_r};
    case (state)
      S_SWEEP: begin
        wr_en    = 1'b1;
        wr_entry = '{vld: 1'b0, key: key_r, data: data_r};
      end
      S_SCAN: begin
        if (iss == lim && !pend && mode_r == MODE_ADD && found_free && !hit) begin
          wr_en   = 1'b1;
          wr_addr = free_idx;
        end
      end
      S_RCHK: begin
        if (rd_entry.vld) begin
          wr_en    = 1'b1;
          wr_addr  = ridx;
          wr_entry = '{vld: 1'b0, key: rd_entry.key, data: rd_entry.data};
        end
      end
      default: begin
      end
    endcase
  end

  kst_ram #(
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_active <= 5'd16;
    end else if (cfg_wr_en) begin
      cfg_active <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      init      <= 1'b1;
      sw        <= '0;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= rd_en;
      if (rd_en) begin
        chk <= rd_addr;
      end
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          if (sw == IW'(SLOTS - 1)) begin
            sw    <= '0;
            init  <= 1'b0;
            state <= init ? S_IDLE : S_FINISH;
          end else begin
            sw <= sw + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            mode_r     <= mode;
            key_r      <= key_id;
            data_r     <= entry_data;
            ridx       <= idx_wide[IW-1:0];
            lim        <= lim_next;
            iss        <= '0;
            found_free <= 1'b0;
            hit        <= 1'b0;
            slot_r     <= '0;
            dout_r     <= '0;
            case (mode)
              MODE_ADD, MODE_FIND: begin
                st_r  <= ST_OK;
                state <= S_SCAN;
              end
              MODE_REMOVE: begin
                if (idx_in_range) begin
                  st_r  <= ST_OK;
                  state <= S_RCHK;
                end else begin
                  st_r  <= ST_EMPTY;
                  state <= S_FINISH;
                end
              end
              default: begin
                st_r  <= ST_OK;
                count <= '0;
                state <= S_SWEEP;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            iss <= iss + 1'b1;
          end
          if (pend) begin
            if (!rd_entry.vld && !found_free) begin
              found_free <= 1'b1;
              free_idx   <= chk;
            end
            if (rd_entry.vld && rd_entry.key == key_r && !hit) begin
              hit      <= 1'b1;
              hit_idx  <= chk;
              hit_data <= rd_entry.data;
            end
          end
          if (iss == lim && !pend) begin
            // Every active slot has been seen: decide and commit.
            state <= S_FINISH;
            if (mode_r == MODE_ADD) begin
              if (!found_free) begin
                st_r <= ST_FULL;
              end else if (hit) begin
                st_r <= ST_DUPLICATE;
              end else begin
                slot_r <= free_idx;
                count  <= count + 1'b1;
              end
            end else if (hit) begin
              slot_r <= hit_idx;
              dout_r <= hit_data;
            end else begin
              st_r <= ST_NOT_FOUND;
            end
          end
        end
        S_RCHK: begin
          if (rd_entry.vld) begin
            count <= count - 1'b1;
          end else begin
            st_r <= ST_EMPTY;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          // Hold the result until the output register is free.
          if (!out_valid || out_ready) begin
            status     <= st_r;
            slot_out   <= 4'(slot_r);
            data_out   <= dout_r;
            live_count <= 5'(count);
            out_valid  <= 1'b1;
            state      <= S_HOLD;
          end
        end
        S_HOLD: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- verif/keyed_slot_table_checker.sv -----
`timescale 1ns / 1ps

module keyed_slot_table_checker #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [15:0] key_id,
  input  logic [31:0] entry_data,
  input  logic [3:0]  slot_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [3:0]  slot_out,
  input  logic [31:0] data_out,
  input  logic [4:0]  live_count,
  output int          pending_results,
  output int          mismatch_count
);
  import kst_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] data;
    logic [4:0]  live;
  } table_reply_t;

  logic [SLOTS-1:0] occupied;
  logic [15:0]      stored_key [SLOTS];
  logic [31:0]      stored_data [SLOTS];
  logic [4:0]       live_cnt;
  logic [4:0]       scan_limit;
  table_reply_t     awaited_replies [$];
  int               errs;

  initial begin
    pending_results = 0;
    mismatch_count  = 0;
    errs            = 0;
  end

  // Apply one table operation to the shadow table and return its reply.
  function automatic table_reply_t apply_table_op(logic [1:0] op, logic [15:0] key,
                                                  logic [31:0] data, logic [3:0] idx);
    table_reply_t r;
    int           lim;
    int           free_slot;
    int           hit_slot;
    r.status  = ST_OK;
    r.slot    = '0;
    r.data    = '0;
    r.live    = '0;
    lim       = (scan_limit == 0) ? 1 : (scan_limit > SLOTS) ? SLOTS : int'(scan_limit);
    free_slot = -1;
    hit_slot  = -1;
    // walk downward so the lowest match wins
    for (int i = lim - 1; i >= 0; i--) begin
      if (!occupied[i]) free_slot = i;
      if (occupied[i] && stored_key[i] == key) hit_slot = i;
    end
    case (op)
      MODE_ADD: begin
        if (free_slot < 0) begin
          r.status = ST_FULL;
        end else if (hit_slot >= 0) begin
          r.status = ST_DUPLICATE;
        end else begin
          occupied[free_slot]    = 1'b1;
          stored_key[free_slot]  = key;
          stored_data[free_slot] = data;
          live_cnt               = live_cnt + 5'd1;
          r.slot                 = free_slot[3:0];
        end
      end
      MODE_FIND: begin
        if (hit_slot < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.slot = hit_slot[3:0];
          r.data = stored_data[hit_slot];
        end
      end
      MODE_REMOVE: begin
        if (int'(idx) >= SLOTS || !occupied[idx]) begin
          r.status = ST_EMPTY;
        end else begin
          occupied[idx] = 1'b0;
          if (live_cnt != 0) live_cnt = live_cnt - 5'd1;
        end
      end
      default: begin
        occupied = '0;
        live_cnt = '0;
      end
    endcase
    r.live = live_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    table_reply_t want;
    if (rst) begin
      occupied   = '0;
      live_cnt   = '0;
      scan_limit = 5'd16;
      awaited_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          $error("result item with no expectation waiting");
          errs++;
        end else begin
          want = awaited_replies.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errs++;
          end
          if (slot_out !== want.slot) begin
            $error("slot_out: expected %0d, got %0d", want.slot, slot_out);
            errs++;
          end
          if (data_out !== want.data) begin
            $error("data_out: expected %h, got %h", want.data, data_out);
            errs++;
          end
          if (live_count !== want.live) begin
            $error("live_count: expected %0d, got %0d", want.live, live_count);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_replies.push_back(apply_table_op(mode, key_id, entry_data, slot_index));
      end
      if (cfg_wr_en) scan_limit = cfg_wr_data;
    end
    pending_results <= awaited_replies.size();
    mismatch_count  <= errs;
  end

endmodule

// ----- verif/keyed_slot_table_tb.sv -----
`timescale 1ns / 1ps

module keyed_slot_table_tb;
  import kst_pkg::*;

  localparam int SLOTS = 16;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 83;
  localparam logic [4:0] PHASE_LIMITS [PHASES] =
    '{5'd16, 5'd1, 5'd3, 5'd31, 5'd17, 5'd8, 5'd0, 5'd5, 5'd12, 5'd2};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = MODE_FIND;
  logic [15:0] key_id = '0;
  logic [31:0] entry_data = '0;
  logic [3:0]  slot_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [3:0]  slot_out;
  logic [31:0] data_out;
  logic [4:0]  live_count;
  logic        steady = 1'b0;
  logic [15:0] key_pool [24];
  int          pending_results;
  int          mismatch_count;

  always #4 clk = ~clk;

  keyed_slot_table #(.SLOTS(SLOTS)) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .key_id     (key_id),
    .entry_data (entry_data),
    .slot_index (slot_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .slot_out   (slot_out),
    .data_out   (data_out),
    .live_count (live_count)
  );

  keyed_slot_table_checker #(.SLOTS(SLOTS)) u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .key_id         (key_id),
    .entry_data     (entry_data),
    .slot_index     (slot_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .slot_out       (slot_out),
    .data_out       (data_out),
    .live_count     (live_count),
    .pending_results(pending_results),
    .mismatch_count (mismatch_count)
  );

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 28);
  end

  // Present one item and hold it until the table takes it.
  task automatic send_op(input logic [1:0] op, input logic [15:0] key,
                         input logic [31:0] data, input logic [3:0] idx);
    if (!steady) begin
      while ($urandom_range(0, 99) < 28) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    mode       <= op;
    key_id     <= key;
    entry_data <= data;
    slot_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic set_active(input logic [4:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int          pick;
    logic [15:0] key;
    logic [31:0] data;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty table, then extremes of key and data
    send_op(MODE_FIND, 16'h0000, 32'h0, 4'd0);
    send_op(MODE_REMOVE, 16'h0, 32'h0, 4'd0);
    send_op(MODE_REMOVE, 16'h0, 32'h0, 4'd15);
    send_op(MODE_ADD, 16'h0000, 32'h0000_0000, 4'd0);
    send_op(MODE_ADD, 16'hFFFF, 32'hFFFF_FFFF, 4'd15);
    send_op(MODE_ADD, 16'h0000, 32'h1111_1111, 4'd0);
    send_op(MODE_FIND, 16'hFFFF, 32'h0, 4'd0);
    send_op(MODE_FIND, 16'h0000, 32'h0, 4'd0);
    send_op(MODE_REMOVE, 16'h0, 32'h0, 4'd0);
    send_op(MODE_ADD, 16'h1234, 32'hA5A5_A5A5, 4'd0);
    send_op(MODE_ADD, 16'h2222, 32'h5A5A_5A5A, 4'd0);
    send_op(MODE_ADD, 16'h3333, 32'h0F0F_0F0F, 4'd0);

    // shrink the scan so slots 2 and 3 are hidden
    settle();
    set_active(5'd2);
    send_op(MODE_FIND, 16'h3333, 32'h0, 4'd0);
    send_op(MODE_ADD, 16'h3333, 32'h7777_7777, 4'd0);
    send_op(MODE_REMOVE, 16'h0, 32'h0, 4'd3);
    send_op(MODE_REMOVE, 16'h0, 32'h0, 4'd15);

    // zero acts as one slot
    settle();
    set_active(5'd0);
    send_op(MODE_ADD, 16'h4444, 32'h4444_4444, 4'd0);
    send_op(MODE_FIND, 16'h1234, 32'h0, 4'd0);
    send_op(MODE_CLEAR, 16'h0, 32'h0, 4'd0);
    send_op(MODE_ADD, 16'h4444, 32'h4444_4444, 4'd0);
    send_op(MODE_ADD, 16'h5555, 32'h5555_5555, 4'd0);

    // over-range value acts as the full table
    settle();
    set_active(5'd31);
    send_op(MODE_ADD, 16'h5555, 32'h5555_5555, 4'd0);
    send_op(MODE_FIND, 16'h5555, 32'h0, 4'd0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_active(PHASE_LIMITS[p]);
      steady <= (p == 4);
      foreach (key_pool[k]) key_pool[k] = 16'($urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 6 && n == PHASE_ITEMS / 2) settle();
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 4) != 0) key = key_pool[$urandom_range(0, 23)];
        else key = 16'($urandom);
        case ($urandom_range(0, 9))
          0:       data = 32'h0000_0000;
          1:       data = 32'hFFFF_FFFF;
          default: data = $urandom;
        endcase
        if (pick < 50) send_op(MODE_ADD, key, data, 4'($urandom));
        else if (pick < 78) send_op(MODE_FIND, key, data, 4'($urandom));
        else if (pick < 98) send_op(MODE_REMOVE, key, data, 4'($urandom_range(0, 15)));
        else send_op(MODE_CLEAR, key, data, 4'($urandom));
      end
    end

    settle();
    steady <= 1'b0;
    // let any stray result surface
    repeat (SLOTS + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("keyed_slot_table test passed");
    end else begin
      $display("keyed_slot_table test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("keyed_slot_table test failed");
    $finish;
  end

endmodule
